FILE: hw/rtl/i4dq_pkg.sv
// ----------------------------------------------------------------------------
// i4dq_pkg
// Shared types and constants for the int4 group dequantizer.
// ----------------------------------------------------------------------------
package i4dq_pkg;

  localparam int unsigned LANES = 8;

  localparam logic [15:0] HALF_QNAN = 16'h7E00;
  localparam logic [14:0] HALF_INF  = 15'h7C00;
  localparam logic [4:0]  EXP_MAX   = 5'h1F;

  typedef logic [4:0] lane_shift_t;
  typedef lane_shift_t [LANES-1:0] shift_tab_t;

  // nibble shift per output lane
  localparam shift_tab_t LANE_SHIFT = '{5'd28, 5'd12, 5'd24, 5'd8,
                                        5'd20, 5'd4, 5'd16, 5'd0};

  // per-lane stage-one result
  typedef struct packed {
    logic        special;
    logic [15:0] spec_val;
    logic        sgn;
    logic [14:0] prod;
    logic [4:0]  ex;
  } lane_mid_t;

endpackage

FILE: hw/rtl/i4dq_lane.sv
// ----------------------------------------------------------------------------
// i4dq_lane
// One lane: (w - z) * scale, rounded once to fp16, two pipeline stages.
// ----------------------------------------------------------------------------
module i4dq_lane (
  input  logic        clk,
  input  logic        adv,
  input  logic [3:0]  w,
  input  logic [3:0]  z,
  input  logic [15:0] scale,
  output logic [15:0] value
);

  i4dq_pkg::lane_mid_t mid_nxt, mid_r;
  logic [15:0] value_nxt, value_r;

  logic signed [4:0] d;
  logic [3:0]  ad;
  logic [10:0] mant;

  always_comb begin
    d = $signed({1'b0, w}) - $signed({1'b0, z});
    ad = d[4] ? 4'(-d) : d[3:0];
    mant = (scale[14:10] == 5'd0) ? {1'b0, scale[9:0]} : {1'b1, scale[9:0]};
    mid_nxt.sgn = scale[15] ^ d[4];
    mid_nxt.prod = 15'(mant) * 15'(ad);
    mid_nxt.ex = scale[14:10];
    mid_nxt.special = (scale[14:10] == i4dq_pkg::EXP_MAX);
    if (scale[9:0] != 10'd0) begin
      mid_nxt.spec_val = scale | 16'h0200;
    end else if (ad == 4'd0) begin
      mid_nxt.spec_val = i4dq_pkg::HALF_QNAN;
    end else begin
      mid_nxt.spec_val = {mid_nxt.sgn, i4dq_pkg::HALF_INF};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mid_r <= mid_nxt;
    end
    value_r <= value_nxt;
  end

  // value = prod * 2^(e), e = ex-25 (normal) or -24 (subnormal)
  logic [3:0]  p;
  logic signed [7:0] e, q, sh;
  logic [14:0] n, rem, half, sh_mask;
  logic [15:0] bits;
  logic        up;

  always_comb begin
    p = 4'd0;
    for (int k = 0; k < 15; k++) begin
      if (mid_r.prod[k]) p = 4'(k);
    end
    e = (mid_r.ex == 5'd0) ? -8'sd24 : $signed({3'b0, mid_r.ex}) - 8'sd25;
    q = $signed({4'b0, p}) + e;
    if (q < -8'sd14) q = -8'sd14;
    q = q - 8'sd10;
    sh = q - e;
    n = 15'd0;
    rem = 15'd0;
    half = 15'd0;
    sh_mask = 15'd0;
    up = 1'b0;
    if (sh <= 8'sd0) begin
      n = mid_r.prod << 4'(-sh);
    end else begin
      sh_mask = (15'd1 << 4'(sh)) - 15'd1;
      rem = mid_r.prod & sh_mask;
      half = 15'd1 << 4'(sh - 8'sd1);
      n = mid_r.prod >> 4'(sh);
      up = (rem > half) || ((rem == half) && n[0]);
    end
    bits = 16'({q + 8'sd24, 10'd0}) + 16'(n) + 16'(up);
    if (bits >= 16'(i4dq_pkg::HALF_INF)) bits = 16'(i4dq_pkg::HALF_INF);
    if (mid_r.special) begin
      value_nxt = mid_r.spec_val;
    end else if (mid_r.prod == 15'd0) begin
      value_nxt = {mid_r.sgn, 15'd0};
    end else begin
      value_nxt = {mid_r.sgn, bits[14:0]};
    end
  end

  assign value = value_r;

endmodule

FILE: hw/rtl/int4_group_dequantize_fp16.sv
// ----------------------------------------------------------------------------
// int4_group_dequantize_fp16
// AWQ int4 weight dequantizer with fp16 scales, eight lanes per beat.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_packed_weights, in_packed_zeros and in_scale_0..7 with start
//   high; the beat is taken at that edge (busy is always low, the pipeline
//   never stalls).
//   out_valid then pulses for one cycle with out_value_0..7.
//   Lane i takes the nibble at shift 0,16,4,20,8,24,12,28 of both words.
//   Throughput: one beat per cycle; each beat passes the lane multiply stage
//   and then the round/pack stage.
//   Reset clears the valid pipeline only; the receiver cannot stall, so
//   every result is shown exactly once.
// ----------------------------------------------------------------------------
module int4_group_dequantize_fp16 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_packed_weights,
  input  logic [31:0] in_packed_zeros,
  input  logic [15:0] in_scale_0,
  input  logic [15:0] in_scale_1,
  input  logic [15:0] in_scale_2,
  input  logic [15:0] in_scale_3,
  input  logic [15:0] in_scale_4,
  input  logic [15:0] in_scale_5,
  input  logic [15:0] in_scale_6,
  input  logic [15:0] in_scale_7,
  output logic        out_valid,
  output logic [15:0] out_value_0,
  output logic [15:0] out_value_1,
  output logic [15:0] out_value_2,
  output logic [15:0] out_value_3,
  output logic [15:0] out_value_4,
  output logic [15:0] out_value_5,
  output logic [15:0] out_value_6,
  output logic [15:0] out_value_7
);

  logic [1:0] vld_r, vld_nxt;
  logic [15:0] scales [i4dq_pkg::LANES];
  logic [15:0] vals [i4dq_pkg::LANES];

  assign busy = 1'b0;
  assign scales[0] = in_scale_0;
  assign scales[1] = in_scale_1;
  assign scales[2] = in_scale_2;
  assign scales[3] = in_scale_3;
  assign scales[4] = in_scale_4;
  assign scales[5] = in_scale_5;
  assign scales[6] = in_scale_6;
  assign scales[7] = in_scale_7;

  for (genvar i = 0; i < i4dq_pkg::LANES; i++) begin : g_lane
    i4dq_lane u_lane (
      .clk   (clk),
      .adv   (1'b1),
      .w     (4'(in_packed_weights >> i4dq_pkg::LANE_SHIFT[i])),
      .z     (4'(in_packed_zeros >> i4dq_pkg::LANE_SHIFT[i])),
      .scale (scales[i]),
      .value (vals[i])
    );
  end

  assign vld_nxt = {vld_r[0], start & ~busy};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 2'b00;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign out_valid   = vld_r[1];
  assign out_value_0 = vals[0];
  assign out_value_1 = vals[1];
  assign out_value_2 = vals[2];
  assign out_value_3 = vals[3];
  assign out_value_4 = vals[4];
  assign out_value_5 = vals[5];
  assign out_value_6 = vals[6];
  assign out_value_7 = vals[7];

`ifndef ASSERT_OFF
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid) else $error("missed result");
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(vld_r[0])) else $error("spurious result");
  a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
`endif

endmodule

FILE: bench/tb_int4_group_dequantize_fp16.sv
// ----------------------------------------------------------------------------
// tb_int4_group_dequantize_fp16
// Self-checking bench for the int4 group dequantizer: a queue-fed driver sends
// packed weight/zero words with fp16 scales, a monitor checks each result beat
// lane by lane against an integer model of the exact product rounded to fp16.
// ----------------------------------------------------------------------------
module tb_int4_group_dequantize_fp16;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [31:0] wq;
    logic [31:0] zq;
    logic [15:0] sc [i4dq_pkg::LANES];
  } beat_t;

  typedef struct {
    logic [15:0] v [i4dq_pkg::LANES];
  } half8_t;

  localparam int MAX_CYCLES = 200000;
  localparam int SHIFT_OF [i4dq_pkg::LANES] = '{0, 16, 4, 20, 8, 24, 12, 28};

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [31:0] in_packed_weights;
  logic [31:0] in_packed_zeros;
  logic [15:0] in_scale [i4dq_pkg::LANES];
  logic        out_valid;
  logic [15:0] out_value [i4dq_pkg::LANES];

  beat_t  pending_beats [$];
  half8_t expected_halves [$];
  int     send_idle_pct;
  int     errors;
  int     cycles;
  int     sent_count;
  int     recv_count;
  bit     hold_send;

  int4_group_dequantize_fp16 u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_packed_weights(in_packed_weights), .in_packed_zeros(in_packed_zeros),
    .in_scale_0(in_scale[0]), .in_scale_1(in_scale[1]),
    .in_scale_2(in_scale[2]), .in_scale_3(in_scale[3]),
    .in_scale_4(in_scale[4]), .in_scale_5(in_scale[5]),
    .in_scale_6(in_scale[6]), .in_scale_7(in_scale[7]),
    .out_valid(out_valid),
    .out_value_0(out_value[0]), .out_value_1(out_value[1]),
    .out_value_2(out_value[2]), .out_value_3(out_value[3]),
    .out_value_4(out_value[4]), .out_value_5(out_value[5]),
    .out_value_6(out_value[6]), .out_value_7(out_value[7])
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic logic [15:0] dequant_half(int d, logic [15:0] s);
    logic        sgn;
    int unsigned ad, mant, prod, n, rem, half, bits;
    int          e, p, q, sh;
    sgn = s[15] ^ (d < 0);
    ad = (d < 0) ? -d : d;
    if (s[14:10] == i4dq_pkg::EXP_MAX) begin
      if (s[9:0] != 0) return s | 16'h0200;
      if (ad == 0) return i4dq_pkg::HALF_QNAN;
      return {sgn, i4dq_pkg::HALF_INF};
    end
    if (s[14:10] == 0) begin
      mant = s[9:0];
      e = -24;
    end else begin
      mant = {1'b1, s[9:0]};
      e = int'(s[14:10]) - 25;
    end
    prod = mant * ad;
    if (prod == 0) return {sgn, 15'd0};
    p = 0;
    while ((prod >> (p + 1)) != 0) p++;
    q = p + e;
    if (q < -14) q = -14;
    q -= 10;
    sh = q - e;
    if (sh <= 0) begin
      n = prod << (-sh);
    end else begin
      rem = prod & ((1 << sh) - 1);
      half = 1 << (sh - 1);
      n = prod >> sh;
      if (rem > half || (rem == half && n[0])) n++;
    end
    bits = ((q + 24) << 10) + n;
    if (bits >= i4dq_pkg::HALF_INF) bits = i4dq_pkg::HALF_INF;
    return {sgn, bits[14:0]};
  endfunction

  function automatic half8_t dequant_beat(beat_t b);
    half8_t r;
    int     w, z;
    for (int i = 0; i < i4dq_pkg::LANES; i++) begin
      w = (b.wq >> SHIFT_OF[i]) & 4'hF;
      z = (b.zq >> SHIFT_OF[i]) & 4'hF;
      r.v[i] = dequant_half(w - z, b.sc[i]);
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) == 1, 5'd0, 10'($urandom)};
      1: return {$urandom_range(0, 1) == 1, 5'h1F, 10'($urandom_range(0, 3))};
      2: return {$urandom_range(0, 1) == 1, 5'($urandom_range(26, 30)), 10'($urandom)};
      3: return {$urandom_range(0, 1) == 1, 15'($urandom_range(0, 3))};
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_beat(logic [31:0] wq, logic [31:0] zq, logic [15:0] s_all);
    beat_t b;
    b.wq = wq;
    b.zq = zq;
    for (int i = 0; i < i4dq_pkg::LANES; i++) b.sc[i] = s_all;
    pending_beats.push_back(b);
  endtask

  task automatic push_random(int count);
    beat_t b;
    repeat (count) begin
      b.wq = $urandom;
      b.zq = ($urandom_range(0, 4) == 0) ? b.wq : $urandom;
      for (int i = 0; i < i4dq_pkg::LANES; i++) b.sc[i] = rand_scale();
      pending_beats.push_back(b);
    end
  endtask

  task automatic drain();
    while (pending_beats.size() != 0 || sent_count != recv_count) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) expected_halves.push_back(dequant_beat('{in_packed_weights,
          in_packed_zeros, in_scale}));
      if (pending_beats.size() != 0 && !hold_send &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        beat_t b;
        b = pending_beats.pop_front();
        sent_count++;
        start <= 1'b1;
        in_packed_weights <= b.wq;
        in_packed_zeros <= b.zq;
        for (int i = 0; i < i4dq_pkg::LANES; i++) in_scale[i] <= b.sc[i];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      recv_count++;
      if (expected_halves.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat");
      end else begin
        half8_t x;
        x = expected_halves.pop_front();
        for (int i = 0; i < i4dq_pkg::LANES; i++) begin
          if (out_value[i] !== x.v[i]) begin
            errors++;
            if (errors <= 10)
              $display("lane %0d: expected %h got %h", i, x.v[i], out_value[i]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_packed_weights = '0;
    in_packed_zeros = '0;
    for (int i = 0; i < i4dq_pkg::LANES; i++) in_scale[i] = '0;
    send_idle_pct = 22;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    push_beat(32'h0000_0000, 32'h0000_0000, 16'h3C00);
    push_beat(32'hFFFF_FFFF, 32'h0000_0000, 16'h3C00);
    push_beat(32'h0000_0000, 32'hFFFF_FFFF, 16'h3C00);
    push_beat(32'hFFFF_FFFF, 32'h0000_0000, 16'h7BFF);
    push_beat(32'h0000_0000, 32'hFFFF_FFFF, 16'h7BFF);
    push_beat(32'h7654_3210, 32'h89AB_CDEF, 16'h5A00);
    push_beat(32'h0000_0000, 32'h0000_0000, 16'hBC00);
    push_beat(32'h0123_4567, 32'h0000_0000, 16'h7C00);
    push_beat(32'h0000_0000, 32'h0000_0000, 16'hFC00);
    push_beat(32'h0000_0000, 32'h1111_1111, 16'h7D55);
    push_beat(32'h1111_1111, 32'h0000_0000, 16'hFC01);
    push_beat(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'h7E00);
    push_beat(32'h3333_3333, 32'h0000_0000, 16'h0001);
    push_beat(32'h0000_0000, 32'h5555_5555, 16'h83FF);
    push_beat(32'hFFFF_FFFF, 32'h0000_0000, 16'h0001);
    push_beat(32'h1111_1111, 32'h0000_0000, 16'h0400);
    push_beat(32'h3333_3333, 32'h0000_0000, 16'h03FF);
    push_beat(32'h3333_3333, 32'h0000_0000, 16'h7AAB);
    push_beat(32'h0000_0000, 32'h0000_0000, 16'h8000);
    push_beat(32'hFEDC_BA98, 32'h0000_0000, 16'hFBFF);
    push_random(380);
    drain();

    hold_send = 1'b1;
    push_random(20);
    repeat (8) @(posedge clk);
    hold_send = 1'b0;
    drain();

    send_idle_pct = 87;
    push_random(400);
    drain();

    send_idle_pct = 0;
    push_random(400);
    drain();
    repeat (10) @(posedge clk);

    if (errors == 0 && expected_halves.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
